### sv/ktsmp_pkg.sv
// Shared types and constants for the keyframe track sampler.
// No dependencies; imported by every module of the block.
package ktsmp_pkg;

	localparam logic [16:0] Q_ONE  = 17'h10000;
	localparam logic [16:0] Q_HALF = 17'h08000;

	typedef enum logic [1:0] {
		OP_WR_TKEY = 2'd0,
		OP_WR_FKEY = 2'd1,
		OP_SAMPLE  = 2'd2,
		OP_UNUSED  = 2'd3
	} op_e;

	localparam logic [2:0] EASE_LINEAR   = 3'd0;
	localparam logic [2:0] EASE_STEP     = 3'd1;
	localparam logic [2:0] EASE_QIN      = 3'd2;
	localparam logic [2:0] EASE_QOUT     = 3'd3;
	localparam logic [2:0] EASE_QINOUT   = 3'd4;
	localparam logic [2:0] EASE_CIN      = 3'd5;
	localparam logic [2:0] EASE_COUT     = 3'd6;
	localparam logic [2:0] EASE_CINOUT   = 3'd7;

	localparam logic CFG_TKEY_COUNT = 1'b0;
	localparam logic CFG_FKEY_COUNT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_F_SCAN,
		S_T_FIRST,
		S_T_LAST,
		S_T_SCAN,
		S_DIV,
		S_INTERP,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         key_index;
		logic [63:0]        time_req;
		logic signed [31:0] in_pos_x;
		logic signed [31:0] in_pos_y;
		logic signed [31:0] in_rotation;
		logic signed [31:0] in_scale;
		logic [2:0]         easing;
		logic [31:0]        in_cell;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] rotation;
		logic signed [31:0] scale;
		logic               transform_valid;
		logic [31:0]        cell_res;
		logic               frame_valid;
	} result_t;

	typedef struct packed {
		logic [63:0]        key_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] rotation;
		logic signed [31:0] scale;
		logic [2:0]         easing;
	} tkey_t;

	typedef struct packed {
		logic [63:0] key_time;
		logic [31:0] sprite;
	} fkey_t;

	typedef struct packed {
		logic               start;
		logic [15:0]        x;
		logic [2:0]         kind;
	} interp_req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] rotation;
		logic signed [31:0] scale;
	} blend_t;

endpackage

### sv/ktsmp_div.sv
// Restoring divider: 16-bit fraction floor(num * 2^16 / den), one bit per cycle.
// Depends on ktsmp_pkg.
module ktsmp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic        zero,
	output logic        done,
	output logic [15:0] quot
);
	import ktsmp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [15:0] q_q;
	logic        zero_q;
	logic [64:0] shifted;
	logic        take;

	assign shifted = {r_q, 1'b0};
	assign take = shifted[64] || (shifted[63:0] >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= num;
			d_q    <= den;
			q_q    <= '0;
			zero_q <= zero;
		end else if (busy_q) begin
			r_q <= take ? (shifted[63:0] - d_q) : shifted[63:0];
			q_q <= {q_q[14:0], take};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? 16'd0 : q_q;

endmodule

### sv/ktsmp_interp.sv
// Easing curve and linear blend of two transform keys, computed step by step.
// Depends on ktsmp_pkg.
module ktsmp_interp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ktsmp_pkg::interp_req_t req,
	input  ktsmp_pkg::tkey_t      key_a,
	input  ktsmp_pkg::tkey_t      key_b,
	output logic                  done,
	output ktsmp_pkg::blend_t     res
);
	import ktsmp_pkg::*;

	localparam logic [17:0] ONE18 = 18'h10000;

	logic        busy_q;
	logic        done_q;
	logic [2:0]  step_q;
	logic [16:0] x_q;
	logic [2:0]  kind_q;
	logic signed [31:0] a_q [4];
	logic signed [31:0] b_q [4];
	logic [33:0] px2_q;
	logic [33:0] pu2_q;
	logic [17:0] cx_q;
	logic [17:0] cu_q;
	logic [16:0] e_q;
	logic signed [31:0] out_q [4];

	logic [16:0] u;
	logic [35:0] cxp;
	logic [35:0] cup;
	logic [17:0] e18;
	logic [1:0]  ch;
	logic [16:0] w0;
	logic signed [49:0] s;

	assign u = Q_ONE - x_q;
	assign cxp = {18'd0, px2_q[33:16]} * {19'd0, x_q};
	assign cup = {18'd0, pu2_q[33:16]} * {19'd0, u};
	assign ch = 2'(step_q - 3'd3);
	assign w0 = Q_ONE - e_q;
	assign s = 50'($signed({1'b0, w0})) * 50'(a_q[ch]) + 50'($signed({1'b0, e_q})) * 50'(b_q[ch]);

	always_comb begin
		case (kind_q)
			EASE_STEP:   e18 = (x_q >= Q_ONE) ? ONE18 : 18'd0;
			EASE_QIN:    e18 = px2_q[33:16];
			EASE_QOUT:   e18 = ONE18 - pu2_q[33:16];
			EASE_QINOUT: e18 = (x_q < Q_HALF) ? px2_q[32:15] : ONE18 - pu2_q[32:15];
			EASE_CIN:    e18 = cx_q;
			EASE_COUT:   e18 = ONE18 - cu_q;
			EASE_CINOUT: e18 = (x_q < Q_HALF) ? {cx_q[15:0], 2'b00}
			                                  : ONE18 - {cu_q[15:0], 2'b00};
			default:     e18 = {1'b0, x_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd6) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= {1'b0, req.x};
			kind_q <= req.kind;
			a_q[0] <= key_a.pos_x;
			a_q[1] <= key_a.pos_y;
			a_q[2] <= key_a.rotation;
			a_q[3] <= key_a.scale;
			b_q[0] <= key_b.pos_x;
			b_q[1] <= key_b.pos_y;
			b_q[2] <= key_b.rotation;
			b_q[3] <= key_b.scale;
		end else if (busy_q) begin
			case (step_q)
				3'd0: begin
					px2_q <= {17'd0, x_q} * {17'd0, x_q};
					pu2_q <= {17'd0, u} * {17'd0, u};
				end
				3'd1: begin
					cx_q <= cxp[33:16];
					cu_q <= cup[33:16];
				end
				3'd2: e_q <= 17'(e18);
				default: out_q[ch] <= s[47:16];
			endcase
		end
	end

	assign done = done_q;
	assign res.pos_x    = out_q[0];
	assign res.pos_y    = out_q[1];
	assign res.rotation = out_q[2];
	assign res.scale    = out_q[3];

endmodule

### sv/keyframe_track_sampler_top.sv
// Keyframe track sampler top: key memories, search sequencer, result register.
// Depends on ktsmp_pkg, ktsmp_div, ktsmp_interp.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready   item   (ktsmp_pkg::item_t)
//  result    out        result_valid/result_ready result (ktsmp_pkg::result_t)
//  config    in         cfg_we                    cfg_idx, cfg_data
//
// A sample scans the frame memory linearly (one read per cycle, up to frame count),
// then the transform memory (up to count + 1 reads), then runs the serial divider
// and the ease/blend unit; the scan length is set by the key counts and the query
// time, and each key memory has a single read port.
// No clearing pass after reset; only counts and control clear.
// A finished result waits in the output register; the next item is taken meanwhile.
module keyframe_track_sampler_top #(
	parameter int MAX_TRANSFORM_KEYS = 64,
	parameter int MAX_FRAME_KEYS     = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ktsmp_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output ktsmp_pkg::result_t result,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [6:0]         cfg_data
);
	import ktsmp_pkg::*;

	localparam int TAW = (MAX_TRANSFORM_KEYS > 1) ? $clog2(MAX_TRANSFORM_KEYS) : 1;
	localparam int FAW = (MAX_FRAME_KEYS > 1) ? $clog2(MAX_FRAME_KEYS) : 1;
	localparam int TCW = $clog2(MAX_TRANSFORM_KEYS + 1);
	localparam int FCW = $clog2(MAX_FRAME_KEYS + 1);
	localparam int JW  = (TCW > FCW) ? TCW : FCW;

	tkey_t tmem [MAX_TRANSFORM_KEYS];
	fkey_t fmem [MAX_FRAME_KEYS];
	tkey_t trd;
	fkey_t frd;

	state_e state_q, state_d;
	logic [6:0] tcnt_q, fcnt_q;
	logic [TCW-1:0] nt;
	logic [FCW-1:0] nf;
	logic [JW-1:0] j_q, j_inc;
	logic [63:0] tq_q;
	logic [31:0] prev_cell_q;
	tkey_t prev_q, cur_q;
	result_t res_q, out_q;
	logic out_valid_q;

	logic t_ren, f_ren;
	logic [TAW-1:0] t_raddr;
	logic [FAW-1:0] f_raddr;
	logic accept, is_sample, t_we, f_we, fstop, flast, tstop, load_out;
	logic div_start, div_done, div_zero;
	logic [15:0] div_q;
	logic [63:0] div_num, div_den;
	interp_req_t ip_req;
	logic ip_done;
	blend_t ip_res;

	always_comb begin
		if ({4'd0, tcnt_q} >= 11'(MAX_TRANSFORM_KEYS)) nt = TCW'(MAX_TRANSFORM_KEYS);
		else nt = TCW'(tcnt_q);
		if ({4'd0, fcnt_q} >= 11'(MAX_FRAME_KEYS)) nf = FCW'(MAX_FRAME_KEYS);
		else nf = FCW'(fcnt_q);
	end

	assign accept    = item_valid && item_ready;
	assign is_sample = item.op == OP_SAMPLE;
	assign t_we = accept && item.op == OP_WR_TKEY
		&& {5'd0, item.key_index} < 11'(MAX_TRANSFORM_KEYS);
	assign f_we = accept && item.op == OP_WR_FKEY
		&& {5'd0, item.key_index} < 11'(MAX_FRAME_KEYS);
	assign j_inc = j_q + 1'b1;
	assign flast = j_inc == JW'(nf);
	assign fstop = frd.key_time > tq_q || flast;
	assign tstop = j_inc == JW'(nt) || trd.key_time > tq_q;
	assign load_out = state_q == S_DONE && (!out_valid_q || result_ready);

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[TAW'(item.key_index)] <= '{key_time: item.time_req, pos_x: item.in_pos_x,
				pos_y: item.in_pos_y, rotation: item.in_rotation,
				scale: item.in_scale, easing: item.easing};
		end
		if (t_ren) trd <= tmem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) fmem[FAW'(item.key_index)] <= '{key_time: item.time_req, sprite: item.in_cell};
		if (f_ren) frd <= fmem[f_raddr];
	end

	// read issue, input ready and divider start
	always_comb begin
		item_ready = 1'b0;
		t_ren = 1'b0;
		t_raddr = '0;
		f_ren = 1'b0;
		f_raddr = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && is_sample) begin
					if (nf != '0) f_ren = 1'b1;
					else if (nt != '0) t_ren = 1'b1;
				end
			end
			S_F_SCAN: begin
				if (!fstop) begin
					f_ren = 1'b1;
					f_raddr = j_inc[FAW-1:0];
				end else if (nt != '0) begin
					t_ren = 1'b1;
				end
			end
			S_T_FIRST: begin
				if (tq_q > trd.key_time) begin
					t_ren = 1'b1;
					t_raddr = TAW'(nt - 1'b1);
				end
			end
			S_T_LAST: begin
				if (tq_q < trd.key_time) begin
					t_ren = 1'b1;
					t_raddr = TAW'(1);
				end
			end
			S_T_SCAN: begin
				if (!tstop) begin
					t_ren = 1'b1;
					t_raddr = j_inc[TAW-1:0];
				end else begin
					div_start = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid && is_sample) begin
					if (nf != '0) state_d = S_F_SCAN;
					else if (nt != '0) state_d = S_T_FIRST;
					else state_d = S_DONE;
				end
			end
			S_F_SCAN:  if (fstop) state_d = (nt != '0) ? S_T_FIRST : S_DONE;
			S_T_FIRST: state_d = (tq_q <= trd.key_time) ? S_DONE : S_T_LAST;
			S_T_LAST:  state_d = (tq_q >= trd.key_time) ? S_DONE : S_T_SCAN;
			S_T_SCAN:  if (tstop) state_d = S_DIV;
			S_DIV:     if (div_done) state_d = S_INTERP;
			S_INTERP:  if (ip_done) state_d = S_DONE;
			S_DONE:    if (load_out) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			tcnt_q      <= '0;
			fcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TKEY_COUNT: tcnt_q <= cfg_data;
					CFG_FKEY_COUNT: fcnt_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && is_sample) begin
					tq_q <= item.time_req;
					j_q  <= '0;
					res_q <= '{pos_x: '0, pos_y: '0, rotation: '0, scale: '0,
						transform_valid: nt != '0, cell_res: '0,
						frame_valid: nf != '0};
				end
			end
			S_F_SCAN: begin
				// first key later than the query ends the scan; the one before is in force, or that first key if it is key 0
				if (frd.key_time > tq_q) begin
					res_q.cell_res <= (j_q == '0) ? frd.sprite : prev_cell_q;
				end else begin
					prev_cell_q <= frd.sprite;
					if (flast) res_q.cell_res <= frd.sprite;
					else j_q <= j_inc;
				end
			end
			S_T_FIRST: begin
				prev_q <= trd;
				if (tq_q <= trd.key_time) begin
					res_q.pos_x <= trd.pos_x;
					res_q.pos_y <= trd.pos_y;
					res_q.rotation <= trd.rotation;
					res_q.scale <= trd.scale;
				end
			end
			S_T_LAST: begin
				j_q <= JW'(1);
				if (tq_q >= trd.key_time) begin
					res_q.pos_x <= trd.pos_x;
					res_q.pos_y <= trd.pos_y;
					res_q.rotation <= trd.rotation;
					res_q.scale <= trd.scale;
				end
			end
			S_T_SCAN: begin
				if (tstop) cur_q <= trd;
				else begin
					prev_q <= trd;
					j_q <= j_inc;
				end
			end
			S_INTERP: begin
				if (ip_done) begin
					res_q.pos_x <= ip_res.pos_x;
					res_q.pos_y <= ip_res.pos_y;
					res_q.rotation <= ip_res.rotation;
					res_q.scale <= ip_res.scale;
				end
			end
			default: ;
		endcase
		if (load_out) out_q <= res_q;
	end

	assign div_num  = tq_q - prev_q.key_time;
	assign div_den  = trd.key_time - prev_q.key_time;
	assign div_zero = div_den == 64'd0 || tq_q < prev_q.key_time || div_num >= div_den;

	ktsmp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.zero  (div_zero),
		.done  (div_done),
		.quot  (div_q)
	);

	assign ip_req.start = state_q == S_DIV && div_done;
	assign ip_req.x     = div_q;
	assign ip_req.kind  = prev_q.easing;

	ktsmp_interp u_interp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ip_req),
		.key_a (prev_q),
		.key_b (cur_q),
		.done  (ip_done),
		.res   (ip_res)
	);

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

### sv/ktsmp_checker.sv
// Port-level checks for the keyframe track sampler, bound to the top level.
// Depends on ktsmp_pkg and keyframe_track_sampler_top.
module ktsmp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input ktsmp_pkg::item_t   item,
	input logic               result_valid,
	input logic               result_ready,
	input ktsmp_pkg::result_t result
);
	import ktsmp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.op == OP_SAMPLE |=> !item_ready)
		else $error("new beat taken while a sample is in progress");

	a_no_track: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.transform_valid |-> result.pos_x == 0
		&& result.pos_y == 0 && result.rotation == 0 && result.scale == 0)
		else $error("transform fields nonzero without a transform track");

	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_valid |-> result.cell_res == 0)
		else $error("sprite nonzero without a frame track");

endmodule

bind keyframe_track_sampler_top ktsmp_checker u_ktsmp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

### verif/tb_keyframe_track_sampler_top.sv
// Testbench for keyframe_track_sampler_top: directed table, then random phases of
// key loads and samples checked against an in-bench track predictor.
// Depends on ktsmp_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_keyframe_track_sampler_top;
	import ktsmp_pkg::*;

	localparam int NKEYS    = 64;
	localparam int DRAIN    = 300;
	localparam int N_PHASES = 10;

	typedef struct {
		bit         is_cfg;
		logic       cfg_i;
		logic [6:0] cfg_v;
		item_t      it;
		bit         typed;
		result_t    exp;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_we = 1'b0;
	logic    cfg_idx = 1'b0;
	logic [6:0] cfg_data = '0;

	// predictor copy of the key tables and counts
	tkey_t    tk_tab [NKEYS];
	fkey_t    fk_tab [NKEYS];
	int       tk_count, fk_count;
	result_t  samples_due [$];
	int       fails = 0;
	int       rdy_wait = 0;
	bit       no_stall = 0;
	row_t     rows [$];

	keyframe_track_sampler_top u_top (.*);

	always #2 clk = ~clk;

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [15:0] seg_frac(logic [63:0] num, logic [63:0] den);
		logic [63:0] r;
		logic [15:0] q;
		logic        c;
		r = num;
		q = '0;
		for (int i = 0; i < 16; i++) begin
			c = r[63];
			r = r << 1;
			q = q << 1;
			if (c || r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] qm(logic [63:0] a, logic [63:0] b);
		return (a * b) >> 16;
	endfunction

	function automatic logic [63:0] eased(logic [2:0] kind, logic [63:0] x);
		logic [63:0] u;
		u = 64'(Q_ONE) - x;
		case (kind)
			EASE_STEP:   return (x >= 64'(Q_ONE)) ? 64'(Q_ONE) : 64'd0;
			EASE_QIN:    return qm(x, x);
			EASE_QOUT:   return 64'(Q_ONE) - qm(u, u);
			EASE_QINOUT: return (x < 64'(Q_HALF)) ? (2 * x * x) >> 16
				: 64'(Q_ONE) - ((2 * u * u) >> 16);
			EASE_CIN:    return qm(qm(x, x), x);
			EASE_COUT:   return 64'(Q_ONE) - qm(qm(u, u), u);
			EASE_CINOUT: return (x < 64'(Q_HALF)) ? 4 * qm(qm(x, x), x)
				: 64'(Q_ONE) - 4 * qm(qm(u, u), u);
			default:     return x;
		endcase
	endfunction

	function automatic logic [31:0] mix(logic signed [31:0] a, logic signed [31:0] b,
			logic [63:0] e);
		longint s;
		s = longint'(64'(Q_ONE) - e) * longint'(a) + longint'(e) * longint'(b);
		return 32'(s >>> 16);
	endfunction

	// Applies one accepted beat to the tables; returns 1 with the sample result.
	function automatic bit track_step(item_t it, output result_t r);
		int          nt, nf, j;
		logic [63:0] tq, span, e;
		r = '0;
		tq = it.time_req;
		if (it.op == OP_WR_TKEY) begin
			tk_tab[it.key_index] = '{it.time_req, it.in_pos_x, it.in_pos_y,
				it.in_rotation, it.in_scale, it.easing};
			return 0;
		end
		if (it.op == OP_WR_FKEY) begin
			fk_tab[it.key_index] = '{it.time_req, it.in_cell};
			return 0;
		end
		if (it.op != OP_SAMPLE)
			return 0;
		nt = (tk_count < NKEYS) ? tk_count : NKEYS;
		nf = (fk_count < NKEYS) ? fk_count : NKEYS;
		if (nt > 0) begin
			r.transform_valid = 1'b1;
			if (tq <= tk_tab[0].key_time) j = 0;
			else if (tq >= tk_tab[nt-1].key_time) j = nt - 1;
			else j = -1;
			if (j >= 0) begin
				r.pos_x = tk_tab[j].pos_x;
				r.pos_y = tk_tab[j].pos_y;
				r.rotation = tk_tab[j].rotation;
				r.scale = tk_tab[j].scale;
			end else begin
				j = 1;
				while (j < nt - 1 && tk_tab[j].key_time <= tq)
					j++;
				span = tk_tab[j].key_time - tk_tab[j-1].key_time;
				if (span == 0 || tq < tk_tab[j-1].key_time
						|| tq - tk_tab[j-1].key_time >= span)
					e = eased(tk_tab[j-1].easing, 64'd0);
				else
					e = eased(tk_tab[j-1].easing,
						64'(seg_frac(tq - tk_tab[j-1].key_time, span)));
				r.pos_x = mix(tk_tab[j-1].pos_x, tk_tab[j].pos_x, e);
				r.pos_y = mix(tk_tab[j-1].pos_y, tk_tab[j].pos_y, e);
				r.rotation = mix(tk_tab[j-1].rotation, tk_tab[j].rotation, e);
				r.scale = mix(tk_tab[j-1].scale, tk_tab[j].scale, e);
			end
		end
		if (nf > 0) begin
			r.frame_valid = 1'b1;
			j = 0;
			while (j < nf && fk_tab[j].key_time <= tq)
				j++;
			r.cell_res = fk_tab[(j == 0) ? 0 : j - 1].sprite;
		end
		return 1;
	endfunction

	function automatic item_t tkey_item(logic [5:0] idx, logic [63:0] t,
			logic [31:0] x, logic [31:0] y, logic [31:0] rot, logic [31:0] scl,
			logic [2:0] ease);
		item_t it;
		it = '0;
		it.op = OP_WR_TKEY;
		it.key_index = idx;
		it.time_req = t;
		it.in_pos_x = x;
		it.in_pos_y = y;
		it.in_rotation = rot;
		it.in_scale = scl;
		it.easing = ease;
		return it;
	endfunction

	function automatic item_t fkey_item(logic [5:0] idx, logic [63:0] t, logic [31:0] c);
		item_t it;
		it = '0;
		it.op = OP_WR_FKEY;
		it.key_index = idx;
		it.time_req = t;
		it.in_cell = c;
		return it;
	endfunction

	function automatic item_t sample_item(logic [63:0] t);
		item_t it;
		it = '0;
		it.op = OP_SAMPLE;
		it.time_req = t;
		return it;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// random content in every field; op and index chosen by caller
	function automatic item_t noise_item();
		logic [255:0] raw;
		item_t        it;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()};
		it = raw[$bits(item_t)-1:0];
		return it;
	endfunction

	task automatic send(item_t it, bit typed, result_t exp);
		result_t r;
		int      gap;
		gap = no_stall ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (track_step(it, r))
			samples_due.push_back(typed ? exp : r);
	endtask

	// hold off until the block is idle, then write a count register
	task automatic set_count(logic idx, logic [6:0] val);
		@(negedge clk);
		item_valid <= 1'b0;
		while (samples_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TKEY_COUNT) tk_count = val;
		else fk_count = val;
	endtask

	always @(negedge clk) begin
		if (rdy_wait > 0) begin
			result_ready <= 1'b0;
			rdy_wait--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && result_ready) begin
			rdy_wait = no_stall ? 0 : $urandom_range(0, 19);
			if (samples_due.size() == 0) begin
				$error("result beat with no sample pending");
				fails++;
			end else begin
				e = samples_due.pop_front();
				if (result.pos_x !== e.pos_x) begin
					$error("pos_x exp %h got %h", e.pos_x, result.pos_x); fails++;
				end
				if (result.pos_y !== e.pos_y) begin
					$error("pos_y exp %h got %h", e.pos_y, result.pos_y); fails++;
				end
				if (result.rotation !== e.rotation) begin
					$error("rotation exp %h got %h", e.rotation, result.rotation); fails++;
				end
				if (result.scale !== e.scale) begin
					$error("scale exp %h got %h", e.scale, result.scale); fails++;
				end
				if (result.transform_valid !== e.transform_valid) begin
					$error("transform_valid exp %b got %b", e.transform_valid,
						result.transform_valid); fails++;
				end
				if (result.cell_res !== e.cell_res) begin
					$error("cell_res exp %h got %h", e.cell_res, result.cell_res); fails++;
				end
				if (result.frame_valid !== e.frame_valid) begin
					$error("frame_valid exp %b got %b", e.frame_valid,
						result.frame_valid); fails++;
				end
			end
		end
	end

	initial begin
		row_t        rw;
		item_t       it;
		result_t     none;
		int          nt_reg, nf_reg, ntk, nfk, waited, k, mode;
		logic [63:0] t, base;
		int          ph_t [N_PHASES] = '{0, 1, 2, 5, 64, 127, 3, 8, 16, 4};
		int          ph_f [N_PHASES] = '{3, 1, 0, 7, 64, 100, 3, 2, 16, 9};

		none = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		rw = '{0, CFG_TKEY_COUNT, 7'd0, sample_item(64'd0), 1, '0};
		rows.push_back(rw);
		rw.it = noise_item(); rw.it.op = OP_UNUSED; rw.typed = 0;
		rows.push_back(rw);
		rw.it = tkey_item(6'd0, 64'd100, 32'h7fffffff, 32'h80000000, 32'h1,
			32'hffffffff, EASE_LINEAR);
		rows.push_back(rw);
		rw.it = tkey_item(6'd1, 64'd200, 32'h80000000, 32'h7fffffff, 32'hffffffff,
			32'h1, EASE_LINEAR);
		rows.push_back(rw);
		rw.it = fkey_item(6'd0, 64'd50, 32'hffffffff);
		rows.push_back(rw);
		rw.it = fkey_item(6'd1, 64'd150, 32'h7);
		rows.push_back(rw);
		rw.is_cfg = 1; rw.cfg_i = CFG_TKEY_COUNT; rw.cfg_v = 7'd2;
		rows.push_back(rw);
		rw.cfg_i = CFG_FKEY_COUNT;
		rows.push_back(rw);
		rw.is_cfg = 0; rw.typed = 1;
		rw.it = sample_item(64'd0);
		rw.exp = '{32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff, 1'b1,
			32'hffffffff, 1'b1};
		rows.push_back(rw);
		rw.it = sample_item(64'hffffffffffffffff);
		rw.exp = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h1, 1'b1, 32'h7, 1'b1};
		rows.push_back(rw);
		rw.typed = 0;
		rw.it = sample_item(64'd150);
		rows.push_back(rw);
		for (int ez = 0; ez < 8; ez++) begin
			rw.it = tkey_item(6'd0, 64'd100, 32'h7fffffff, 32'h80000000, 32'h1,
				32'hffffffff, 3'(ez));
			rows.push_back(rw);
			rw.it = sample_item(64'd133 + 64'(ez * 7));
			rows.push_back(rw);
		end

		foreach (rows[i]) begin
			if (rows[i].is_cfg) set_count(rows[i].cfg_i, rows[i].cfg_v);
			else send(rows[i].it, rows[i].typed, rows[i].exp);
		end

		// random phases: load ordered tables, set counts, then mostly samples
		for (int p = 0; p < N_PHASES; p++) begin
			nt_reg = ph_t[p];
			nf_reg = ph_f[p];
			ntk = (nt_reg < NKEYS) ? nt_reg : NKEYS;
			nfk = (nf_reg < NKEYS) ? nf_reg : NKEYS;
			no_stall = (p % 3 == 2);
			base = ($urandom_range(0, 3) == 0) ? rnd64() >> 2 : 64'($urandom_range(0, 500));
			for (int i = 0; i < ntk; i++) begin
				mode = $urandom_range(0, 9);
				if (mode == 0) base = base;
				else if (mode < 7) base = base + $urandom_range(1, 1000);
				else if (mode < 9) base = base + $urandom();
				else base = base + (rnd64() >> $urandom_range(0, 8));
				it = noise_item();
				it.op = OP_WR_TKEY; it.key_index = 6'(i); it.time_req = base;
				send(it, 0, none);
			end
			base = 64'($urandom_range(0, 300));
			for (int i = 0; i < nfk; i++) begin
				base = base + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 1500));
				it = noise_item();
				it.op = OP_WR_FKEY; it.key_index = 6'(i); it.time_req = base;
				send(it, 0, none);
			end
			set_count(CFG_TKEY_COUNT, 7'(nt_reg));
			set_count(CFG_FKEY_COUNT, 7'(nf_reg));
			for (int n = 0; n < 120; n++) begin
				mode = $urandom_range(0, 19);
				it = noise_item();
				if (mode < 14) begin
					it.op = OP_SAMPLE;
					k = $urandom_range(0, NKEYS - 1);
					t = ($urandom_range(0, 1) == 0) ? tk_tab[k].key_time : fk_tab[k].key_time;
					case ($urandom_range(0, 5))
						0: it.time_req = t;
						1: it.time_req = t - $urandom_range(0, 3);
						2, 3: it.time_req = t + $urandom_range(0, 2000);
						4: it.time_req = t + $urandom();
						default: it.time_req = ($urandom_range(0, 2) == 0)
							? {64{$urandom_range(0, 1) == 1}} : rnd64();
					endcase
				end else if (mode < 17) begin
					// rewrite keeps the key's time so the table stays ordered
					it.op = OP_WR_TKEY;
					if (mode == 16) it.op = OP_WR_FKEY;
					if (ntk > 0 && it.op == OP_WR_TKEY) begin
						it.key_index = 6'($urandom_range(0, ntk - 1));
						it.time_req = tk_tab[it.key_index].key_time;
					end else if (nfk > 0 && it.op == OP_WR_FKEY) begin
						it.key_index = 6'($urandom_range(0, nfk - 1));
						it.time_req = fk_tab[it.key_index].key_time;
					end
				end else if (mode == 17) begin
					it.op = ($urandom_range(0, 1) == 0) ? OP_WR_TKEY : OP_WR_FKEY;
				end else begin
					it.op = OP_UNUSED;
				end
				send(it, 0, none);
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		waited = 0;
		while (samples_due.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN) @(posedge clk);
		if (samples_due.size() != 0) begin
			$error("%0d samples never answered", samples_due.size());
			fails++;
		end
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < NKEYS; i++) begin
			tk_tab[i] = '0;
			fk_tab[i] = '0;
		end
		tk_count = 0;
		fk_count = 0;
	end

endmodule
